/* rtl/i2cm_pkg.sv */
// Shared types and codes for the I2C master bit engine.
package i2cm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_ACK   = 3'd5
  } act_t;

  typedef enum logic [5:0] {
    SEQ_IDLE  = 6'b000001,
    SEQ_START = 6'b000010,
    SEQ_STOP  = 6'b000100,
    SEQ_WRITE = 6'b001000,
    SEQ_READ  = 6'b010000,
    SEQ_ACK   = 6'b100000
  } seq_t;

  localparam int PhaseW = 5;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_byte;
    logic       ack_to_send;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_received;
  } out_item_t;

endpackage

/* rtl/i2cm_in_if.sv */
// Input channel of the I2C master bit engine: valid, ready and one item.
interface i2cm_in_if;
  import i2cm_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/i2cm_out_if.sv */
// Result channel of the I2C master bit engine: valid, ready and one item.
interface i2cm_out_if;
  import i2cm_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/i2c_master_bit_engine_unit.sv */
// I2C master bit engine: phase sequencer for start, stop, byte and ack bit.
// An input beat passes the input register, then the result register holding
// the updated line levels; the phase counter steps once per active tick.
// Throughput: one beat per cycle while the result side is ready.
// Reset (rst_n low, synchronous): idle, SCL and SDA driven high, SDA not
// released, read byte and received ack cleared, both pipeline stages empty.
module i2c_master_bit_engine_unit (
  input logic        clk,
  input logic        rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch
);
  import i2cm_pkg::*;

  logic              in_valid_r;
  in_item_t          in_r;
  logic              out_valid_r;
  out_item_t         out_r;
  logic              advance;

  seq_t              seq_r, seq_nxt;
  logic [PhaseW-1:0] phase_r, phase_nxt, p;
  logic [7:0]        shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              rel_r, rel_nxt;
  logic              ack_r, ack_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              done_nxt;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
  assign p            = phase_r + PhaseW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.data;
    end
  end

  always_comb begin
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    rel_nxt   = rel_r;
    ack_nxt   = ack_r;
    hold_nxt  = hold_r;
    done_nxt  = 1'b0;
    if (in_r.action == ACT_TICK) begin
      if (seq_r != SEQ_IDLE) begin
        phase_nxt = p;
      end
      unique case (seq_r)
        SEQ_IDLE: begin
        end
        SEQ_START: begin
          if (p == PhaseW'(1)) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
        SEQ_STOP: begin
          if (p == PhaseW'(1)) begin
            sda_nxt = 1'b1;
          end else begin
            done_nxt = 1'b1;
          end
        end
        SEQ_ACK: begin
          if (p == PhaseW'(1)) begin
            scl_nxt = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end
        SEQ_WRITE: begin
          if (p <= PhaseW'(16)) begin
            if (p[0]) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              if (p < PhaseW'(16)) begin
                shift_nxt = {shift_r[6:0], 1'b0};
                sda_nxt   = shift_r[6];
              end else begin
                rel_nxt = 1'b1;
              end
            end
          end else if (p == PhaseW'(17)) begin
            scl_nxt = 1'b1;
          end else if (p == PhaseW'(18)) begin
            ack_nxt = in_r.sda_in;
            scl_nxt = 1'b0;
            rel_nxt = 1'b0;
          end else begin
            done_nxt = 1'b1;
          end
        end
        SEQ_READ: begin
          if (p == PhaseW'(1)) begin
            rel_nxt = 1'b1;
          end else if (p < PhaseW'(25)) begin
            case (p)
              5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23: begin
                scl_nxt = 1'b1;
              end
              5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24: begin
                shift_nxt = {shift_r[6:0], in_r.sda_in};
                scl_nxt   = 1'b0;
              end
              default: begin
              end
            endcase
          end else begin
            rel_nxt  = 1'b0;
            hold_nxt = shift_r;
            done_nxt = 1'b1;
          end
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
      if (done_nxt) begin
        seq_nxt   = SEQ_IDLE;
        phase_nxt = '0;
      end
    end else if (seq_r == SEQ_IDLE) begin
      phase_nxt = '0;
      rel_nxt   = 1'b0;
      unique case (in_r.action)
        ACT_START: begin
          seq_nxt = SEQ_START;
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        ACT_STOP: begin
          seq_nxt = SEQ_STOP;
          sda_nxt = 1'b0;
          scl_nxt = 1'b1;
        end
        ACT_ACK: begin
          seq_nxt = SEQ_ACK;
          sda_nxt = in_r.ack_to_send;
          scl_nxt = 1'b1;
        end
        ACT_WRITE: begin
          seq_nxt   = SEQ_WRITE;
          shift_nxt = in_r.write_byte;
          sda_nxt   = in_r.write_byte[7];
        end
        ACT_READ: begin
          seq_nxt   = SEQ_READ;
          shift_nxt = '0;
          sda_nxt   = 1'b1;
        end
        default: begin
          // drop unknown action codes
          phase_nxt = phase_r;
          rel_nxt   = rel_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seq_r       <= SEQ_IDLE;
      phase_r     <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      rel_r       <= 1'b0;
      ack_r       <= 1'b0;
      hold_r      <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        seq_r       <= seq_nxt;
        phase_r     <= phase_nxt;
        shift_r     <= shift_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        rel_r       <= rel_nxt;
        ack_r       <= ack_nxt;
        hold_r      <= hold_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_r.scl_level    <= scl_nxt;
      out_r.sda_level    <= sda_nxt;
      out_r.sda_released <= rel_nxt;
      out_r.busy_res     <= (seq_nxt != SEQ_IDLE);
      out_r.done_res     <= done_nxt;
      out_r.read_data    <= hold_nxt;
      out_r.ack_received <= ack_nxt;
    end
  end

endmodule

/* dv/tb_i2c_master_bit_engine_unit.sv */
// Testbench for the I2C master bit engine: directed script, then random command sequences.
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_unit;
  import i2cm_pkg::*;

  localparam int N_RAND      = 790;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_AT    = 500;
  localparam int STALL_LIMIT = 2000;
  localparam int N_SCRIPT    = 25;

  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;
  localparam act_t       NO_OP     = ACT_TICK;
  localparam out_item_t  NO_LINE   = '0;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] wbyte;
    logic       ackb;
    logic       sda;
    logic [5:0] reps;
    logic       typed;
    out_item_t  want;
  } script_row_t;

  logic clk;
  logic rst_n;

  i2cm_in_if  in_ch ();
  i2cm_out_if out_ch ();

  i2c_master_bit_engine_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // bus model state
  logic [4:0] bus_phase;
  act_t       bus_op;
  logic [7:0] bus_shift;
  logic [7:0] bus_read_hold;
  logic       bus_scl;
  logic       bus_sda;
  logic       bus_released;
  logic       bus_ack;

  out_item_t line_queue[$];

  int  n_sent;
  int  n_dir;
  int  n_checked;
  int  n_done;
  int  n_err;
  int  idle_cycles;
  int  in_calm;
  bit  hold_req;

  script_row_t script [0:N_SCRIPT-1] = '{
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{ACT_RSVD6, 8'hFF, 1'b1, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{ACT_RSVD7, 8'h00, 1'b0, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{ACT_START, 8'hFF, 1'b1, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_STOP,  8'h00, 1'b0, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'hFF, 1'b1, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'h00, 1'b0, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
    '{ACT_TICK,  8'hFF, 1'b1, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
    '{ACT_WRITE, 8'hFF, 1'b0, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_READ,  8'h00, 1'b1, 1'b0, 6'd1,  1'b0, NO_LINE},
    '{ACT_TICK,  8'h5A, 1'b0, 1'b1, 6'd18, 1'b0, NO_LINE},
    '{ACT_TICK,  8'hA5, 1'b1, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
    '{ACT_WRITE, 8'h00, 1'b1, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 6'd19, 1'b0, NO_LINE},
    '{ACT_READ,  8'hFF, 1'b0, 1'b0, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'h00, 1'b1, 1'b1, 6'd24, 1'b0, NO_LINE},
    '{ACT_TICK,  8'hFF, 1'b0, 1'b1, 6'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 8'hFF, 1'b0}},
    '{ACT_READ,  8'h00, 1'b0, 1'b1, 6'd1,  1'b0, NO_LINE},
    '{ACT_TICK,  8'hFF, 1'b1, 1'b0, 6'd25, 1'b0, NO_LINE},
    '{ACT_ACK,   8'h00, 1'b0, 1'b1, 6'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 6'd2,  1'b0, NO_LINE},
    '{ACT_ACK,   8'hFF, 1'b1, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'h00, 1'b0, 1'b1, 6'd2,  1'b0, NO_LINE},
    '{ACT_STOP,  8'hFF, 1'b1, 1'b0, 6'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
    '{ACT_TICK,  8'h00, 1'b0, 1'b0, 6'd2,  1'b0, NO_LINE}
  };

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic reset_bus_model();
    bus_phase     = '0;
    bus_op        = NO_OP;
    bus_shift     = '0;
    bus_read_hold = '0;
    bus_scl       = 1'b1;
    bus_sda       = 1'b1;
    bus_released  = 1'b0;
    bus_ack       = 1'b0;
  endtask

  function automatic out_item_t advance_bus(in_item_t it);
    out_item_t  r;
    logic       fin;
    logic [4:0] p;
    int         q;
    fin = 1'b0;
    if (it.action == ACT_TICK) begin
      if (bus_op != NO_OP) begin
        bus_phase = bus_phase + 5'd1;
        p = bus_phase;
        case (bus_op)
          ACT_START: begin
            if (p == 5'd1) bus_sda = 1'b0;
            else begin
              bus_scl = 1'b0;
              fin = 1'b1;
            end
          end
          ACT_STOP: begin
            if (p == 5'd1) bus_sda = 1'b1;
            else fin = 1'b1;
          end
          ACT_ACK: begin
            if (p == 5'd1) bus_scl = 1'b0;
            else fin = 1'b1;
          end
          ACT_WRITE: begin
            if (p <= 5'd16) begin
              if (p[0]) bus_scl = 1'b1;
              else begin
                bus_scl = 1'b0;
                if (p < 5'd16) begin
                  bus_shift = {bus_shift[6:0], 1'b0};
                  bus_sda = bus_shift[7];
                end else begin
                  bus_released = 1'b1;
                end
              end
            end else if (p == 5'd17) begin
              bus_scl = 1'b1;
            end else if (p == 5'd18) begin
              bus_ack = it.sda_in;
              bus_scl = 1'b0;
              bus_released = 1'b0;
            end else begin
              fin = 1'b1;
            end
          end
          ACT_READ: begin
            if (p == 5'd1) begin
              bus_released = 1'b1;
            end else if (p < 5'd25) begin
              q = (int'(p) - 2) % 3;
              if (q == 0) bus_scl = 1'b1;
              else if (q == 1) begin
                bus_shift = {bus_shift[6:0], it.sda_in};
                bus_scl = 1'b0;
              end
            end else begin
              bus_released = 1'b0;
              bus_read_hold = bus_shift;
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          bus_op = NO_OP;
          bus_phase = '0;
        end
      end
    end else if (bus_op == NO_OP && it.action <= ACT_ACK) begin
      bus_op = act_t'(it.action);
      bus_phase = '0;
      bus_released = 1'b0;
      case (bus_op)
        ACT_START: begin
          bus_sda = 1'b1;
          bus_scl = 1'b1;
        end
        ACT_STOP: begin
          bus_sda = 1'b0;
          bus_scl = 1'b1;
        end
        ACT_ACK: begin
          bus_sda = it.ack_to_send;
          bus_scl = 1'b1;
        end
        ACT_WRITE: begin
          bus_shift = it.write_byte;
          bus_sda = it.write_byte[7];
        end
        default: begin
          bus_shift = '0;
          bus_sda = 1'b1;
        end
      endcase
    end
    r.scl_level    = bus_scl;
    r.sda_level    = bus_sda;
    r.sda_released = bus_released;
    r.busy_res     = (bus_op != NO_OP);
    r.done_res     = fin;
    r.read_data    = bus_read_hold;
    r.ack_received = bus_ack;
    return r;
  endfunction

  task automatic put_beat(in_item_t it, logic typed, out_item_t want);
    out_item_t line;
    int        gap;
    int        r;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    line = advance_bus(it);
    line_queue.push_back(typed ? want : line);
    n_sent++;
    if (n_sent == HOLD_AT) hold_req = 1'b1;
    gap = 0;
    if (in_calm > 0) begin
      in_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) in_calm = $urandom_range(20, 60);
      else if (r < 25) gap = $urandom_range(1, 3);
      else if (r < 28) gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put_rand(logic [2:0] act);
    in_item_t it;
    it = '{act, 8'($urandom), 1'($urandom), 1'($urandom)};
    put_beat(it, 1'b0, NO_LINE);
  endtask

  task automatic cmp_field(string tag, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, tag, want, got);
    end
  endtask

  // result side: check every accepted beat against the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (line_queue.size() == 0) begin
        n_err++;
        $display("%0t: unexpected result beat, expected none, got %h", $time, out_ch.data);
      end else begin
        want = line_queue.pop_front();
        cmp_field("scl_level", 8'(want.scl_level), 8'(out_ch.data.scl_level));
        cmp_field("sda_level", 8'(want.sda_level), 8'(out_ch.data.sda_level));
        cmp_field("sda_released", 8'(want.sda_released), 8'(out_ch.data.sda_released));
        cmp_field("busy_res", 8'(want.busy_res), 8'(out_ch.data.busy_res));
        cmp_field("done_res", 8'(want.done_res), 8'(out_ch.data.done_res));
        cmp_field("read_data", want.read_data, out_ch.data.read_data);
        cmp_field("ack_received", 8'(want.ack_received), 8'(out_ch.data.ack_received));
        n_checked++;
        if (out_ch.data.done_res) n_done++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("i2c_master_bit_engine_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result-side backpressure
  initial begin : sink_side
    int stall;
    int calm;
    int r;
    stall = 0;
    calm = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm > 0) begin
          calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) calm = $urandom_range(30, 80);
          else if (r < 22) stall = $urandom_range(1, 3);
          else if (r < 25) stall = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : source_side
    in_item_t it;
    int       r;
    bit       drained;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    n_sent = 0;
    n_checked = 0;
    n_done = 0;
    n_err = 0;
    in_calm = 0;
    hold_req = 1'b0;
    drained = 1'b0;
    reset_bus_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_SCRIPT; i++) begin
      for (int k = 0; k < int'(script[i].reps); k++) begin
        it = '{script[i].act, script[i].wbyte, script[i].ackb, script[i].sda};
        put_beat(it, script[i].typed, script[i].want);
      end
    end
    n_dir = n_sent;

    while (n_sent - n_dir < N_RAND) begin
      if (!drained && n_sent - n_dir >= DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        while (line_queue.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        put_rand(3'($urandom_range(0, 7)));
      end else begin
        put_rand(3'($urandom_range(int'(ACT_START), int'(ACT_ACK))));
        while (bus_op != NO_OP) begin
          if ($urandom_range(0, 9) == 0) put_rand(3'($urandom_range(1, 7)));
          else put_rand(ACT_TICK);
        end
      end
    end

    in_ch.valid <= 1'b0;
    while (line_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d input beats (%0d from the directed script) over start, stop,",
             n_sent, n_dir);
    $display("write, read, ack and ignored commands; %0d results checked, %0d completions.",
             n_checked, n_done);
    if (n_err == 0) begin
      $display("i2c_master_bit_engine_unit verification clean");
    end else begin
      $display("i2c_master_bit_engine_unit verification failed");
    end
    $finish;
  end

endmodule
